[design/fabp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fabp_pkg;

	// Fixed field widths of the item formats
	localparam int IDX_W  = 8;
	localparam int OFF_W  = 20;
	localparam int CNT_W  = 9;
	localparam int SIZE_W = 13;
	localparam int REQ_W  = 2;
	localparam int STS_W  = 2;

	localparam logic [CNT_W-1:0]  COUNT_RST = 9'd256;
	localparam logic [SIZE_W-1:0] SIZE_RST  = 13'd64;
	localparam logic [SIZE_W-1:0] SIZE_CAP  = 13'd4096;

	// Request kinds
	localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REINIT = 2'd2;

	// Result status codes
	localparam logic [STS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY     = 2'd1;
	localparam logic [STS_W-1:0] STS_NULL_FREE = 2'd2;
	localparam logic [STS_W-1:0] STS_RANGE     = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_INIT,
		ST_POST
	} state_t;

	typedef enum logic [2:0] {
		HEAD_HOLD,
		HEAD_POP,
		HEAD_PUSH,
		HEAD_ZERO,
		HEAD_NULL
	} head_op_t;

	typedef struct packed {
		logic     load_req;
		head_op_t head_op;
		logic     mem_we;
		logic     ctr_clr;
		logic     ctr_inc;
		logic     post;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic             null_handle;
		logic             idx_oor;
		logic             head_empty;
		logic             cnt_zero;
		logic             ctr_last;
		logic             out_busy;
	} dp_status_t;

endpackage

`default_nettype wire

[design/fabp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module fabp_ctrl
	import fabp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire dp_status_t sts,
	output ctrl_cmd_t       cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.head_op = HEAD_HOLD;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_nxt    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.req_type == REQ_REINIT) begin
					if (sts.cnt_zero) begin
						cmd.head_op = HEAD_NULL;
						state_nxt   = ST_POST;
					end else begin
						cmd.ctr_clr = 1'b1;
						state_nxt   = ST_INIT;
					end
				end else if (!sts.out_busy) begin
					cmd.post  = 1'b1;
					state_nxt = ST_IDLE;
					if (sts.req_type == REQ_ALLOC && !sts.head_empty) begin
						cmd.head_op = HEAD_POP;
					end
					if (sts.req_type == REQ_FREE && !sts.null_handle && !sts.idx_oor) begin
						cmd.mem_we  = 1'b1;
						cmd.head_op = HEAD_PUSH;
					end
				end
			end
			ST_INIT: begin
				cmd.mem_we  = 1'b1;
				cmd.ctr_inc = 1'b1;
				if (sts.ctr_last) begin
					cmd.head_op = HEAD_ZERO;
					state_nxt   = ST_POST;
				end
			end
			ST_POST: begin
				if (!sts.out_busy) begin
					cmd.post  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[design/fabp_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module fabp_dp
	import fabp_pkg::*;
#(
	parameter int MAX_BLOCKS = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [SIZE_W-1:0]     cfg_data,
	input  wire logic [REQ_W-1:0]      in_req_type,
	input  wire logic [IDX_W-1:0]      in_block_index,
	input  wire logic                  in_null_handle,
	input  wire ctrl_cmd_t             cmd,
	output dp_status_t                 sts,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [STS_W-1:0]           out_status,
	output logic [IDX_W-1:0]           out_block_index,
	output logic [OFF_W-1:0]           out_byte_offset
);

	localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int LW = $clog2(MAX_BLOCKS + 1);
	localparam int CW = (LW > CNT_W) ? LW : CNT_W;
	localparam int PW = LW + SIZE_W;
	localparam logic [LW-1:0] NULL_LINK = LW'(MAX_BLOCKS);
	localparam logic [CW-1:0] MAX_C     = CW'(MAX_BLOCKS);

	logic [CNT_W-1:0]  block_count_q;
	logic [SIZE_W-1:0] blk_bytes_q;
	logic [REQ_W-1:0]  req_q;
	logic [IDX_W-1:0]  idx_q;
	logic              null_q;
	logic [LW-1:0]     head_q;
	logic [LW-1:0]     ctr_q;
	logic [LW-1:0]     rd_link_q;
	logic              out_valid_q;
	logic [STS_W-1:0]  out_status_q;
	logic [IDX_W-1:0]  out_index_q;
	logic [OFF_W-1:0]  out_offset_q;

	logic [LW-1:0]     link_mem [MAX_BLOCKS];

	logic [CW-1:0]     cnt_w;
	logic [CW-1:0]     eff_cnt;
	logic [SIZE_W-1:0] eff_size;
	logic [LW-1:0]     ctr_nxt;
	logic              ctr_last;
	logic              idx_oor;
	logic              head_empty;
	logic [AW-1:0]     wr_addr;
	logic [LW-1:0]     wr_data;
	logic [PW-1:0]     prod;
	logic [STS_W-1:0]  res_status;
	logic [IDX_W-1:0]  res_index;
	logic [OFF_W-1:0]  res_offset;

	// Saturate the configured count and size
	assign cnt_w      = CW'(block_count_q);
	assign eff_cnt    = (cnt_w > MAX_C) ? MAX_C : cnt_w;
	assign eff_size   = (blk_bytes_q > SIZE_CAP) ? SIZE_CAP : blk_bytes_q;
	assign ctr_nxt    = ctr_q + 1'b1;
	assign ctr_last   = (CW'(ctr_nxt) == eff_cnt);
	assign idx_oor    = (CW'(idx_q) >= eff_cnt);
	assign head_empty = (head_q >= NULL_LINK);
	assign prod       = PW'(head_q) * PW'(eff_size);

	assign sts.req_type    = req_q;
	assign sts.null_handle = null_q;
	assign sts.idx_oor     = idx_oor;
	assign sts.head_empty  = head_empty;
	assign sts.cnt_zero    = (eff_cnt == '0);
	assign sts.ctr_last    = ctr_last;
	assign sts.out_busy    = out_valid_q && !out_ready;

	// Reinit sweep writes the next-block chain, free pushes the old head
	assign wr_addr = cmd.ctr_inc ? AW'(ctr_q) : AW'(idx_q);
	assign wr_data = cmd.ctr_inc ? (ctr_last ? NULL_LINK : ctr_nxt) : head_q;

	always_comb begin
		res_status = STS_OK;
		res_index  = '0;
		res_offset = '0;
		case (req_q)
			REQ_ALLOC: begin
				if (head_empty) begin
					res_status = STS_EMPTY;
				end else begin
					res_index  = IDX_W'(head_q);
					res_offset = OFF_W'(prod);
				end
			end
			REQ_FREE: begin
				if (null_q) begin
					res_status = STS_NULL_FREE;
				end else if (idx_oor) begin
					res_status = STS_RANGE;
				end
			end
			default: begin
				res_status = STS_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= COUNT_RST;
			blk_bytes_q   <= SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BLOCK_COUNT: block_count_q <= cfg_data[CNT_W-1:0];
				CFG_BLOCK_SIZE:  blk_bytes_q   <= cfg_data;
				default: begin
					block_count_q <= block_count_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= NULL_LINK;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.post || (out_valid_q && !out_ready);
			case (cmd.head_op)
				HEAD_POP:  head_q <= rd_link_q;
				HEAD_PUSH: head_q <= LW'(idx_q);
				HEAD_ZERO: head_q <= '0;
				HEAD_NULL: head_q <= NULL_LINK;
				default: begin
					head_q <= head_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q  <= in_req_type;
			idx_q  <= in_block_index;
			null_q <= in_null_handle;
		end
		if (cmd.ctr_clr) begin
			ctr_q <= '0;
		end else if (cmd.ctr_inc) begin
			ctr_q <= ctr_nxt;
		end
		if (cmd.post) begin
			out_status_q <= res_status;
			out_index_q  <= res_index;
			out_offset_q <= res_offset;
		end
	end

	// Link memory: one write port, registered read at the head
	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			link_mem[wr_addr] <= wr_data;
		end
		rd_link_q <= link_mem[AW'(head_q)];
	end

	assign out_valid       = out_valid_q;
	assign out_status      = out_status_q;
	assign out_block_index = out_index_q;
	assign out_byte_offset = out_offset_q;

endmodule

`default_nettype wire

[design/fixed_block_pool_allocator_unit.sv]
// Alloc, free and unused requests: the item is latched in the execute state and the result is registered
// from there, held back while the output is stalled; no new item is taken until the result is posted.
// Reinit: the init sweep writes one link entry per cycle, for the effective block count (capped at
// MAX_BLOCKS), then the result is posted.
// Reset (arst_n low, asynchronous): free list empty, block count 256, 64 bytes per block,
// output empty; link memory is not cleared and holds nothing meaningful until written.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_pool_allocator_unit
	import fabp_pkg::*;
#(
	parameter int MAX_BLOCKS = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Configuration write port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SIZE_W-1:0]    cfg_data,
	// Request stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,  // [7:0] block_index
	input  wire logic [2:0]           s_tuser,  // [1:0] req_type, [2] null_handle
	// Result stream
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [31:0]               m_tdata,  // [7:0] block_index_res, [27:8] byte_offset
	output logic [1:0]                m_tuser   // [1:0] status
);

	ctrl_cmd_t        cmd;
	dp_status_t       sts;
	logic [IDX_W-1:0] res_index;
	logic [OFF_W-1:0] res_offset;

	// Controller: sequences accept, execute, init sweep and result post
	fabp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: config registers, head pointer, link memory, output register
	fabp_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_req_type     (s_tuser[1:0]),
		.in_block_index  (s_tdata),
		.in_null_handle  (s_tuser[2]),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_status      (m_tuser),
		.out_block_index (res_index),
		.out_byte_offset (res_offset)
	);

	// Pack result fields, zero fill to a whole number of bytes
	assign m_tdata = {4'd0, res_offset, res_index};

	// A result is never posted over one still waiting to be taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.post && m_tvalid && !m_tready))
		else $error("result posted while output register is stalled");

	// Pop only from a non-empty free list
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.head_op == HEAD_POP) |-> !sts.head_empty)
		else $error("pop from empty free list");

	// Link memory is written only while an item is in progress
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_we |-> !s_tready)
		else $error("link memory written while idle");

	// An accepted item is never followed by another accept in the next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken while one is in progress");

endmodule

`default_nettype wire

[tb/sv/tb_fixed_block_pool_allocator_unit.sv]
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator_unit;
	import fabp_pkg::*;

	localparam int POOL_MAX = 256;
	localparam logic [CNT_W-1:0] LINK_NULL = 9'd256;
	localparam int SIZE_LIMIT = 4096;
	// Request code left unused by the block: must change nothing
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic [IDX_W-1:0] idx;
		logic             nul;
	} pool_req_t;

	typedef struct packed {
		logic [STS_W-1:0] status;
		logic [IDX_W-1:0] idx;
		logic [OFF_W-1:0] offset;
	} pool_resp_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;  // [7:0] block_index
	logic [2:0] s_tuser = '0;  // [1:0] req_type, [2] null_handle
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;      // [7:0] block_index_res, [27:8] byte_offset
	logic [1:0] m_tuser;       // [1:0] status

	// Shadow of the pool: head, links and the two registers
	logic [CNT_W-1:0]  free_head_q;
	logic [CNT_W-1:0]  link_mem_q [POOL_MAX];
	logic [CNT_W-1:0]  count_reg_q;
	logic [SIZE_W-1:0] size_reg_q;

	pool_req_t  req_backlog [$];
	pool_resp_t due_responses [$];
	pool_req_t  drv_item;
	pool_resp_t got_resp;
	pool_resp_t exp_resp;

	int n_queued = 0;
	int n_accepted = 0;
	int errors = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	bit req_taken = 1'b0;

	fixed_block_pool_allocator_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	// Apply one request to the shadow pool and return the response it must produce.
	// Count and size saturate at the pool size and 4096 before use.
	function automatic pool_resp_t pool_response(input logic [REQ_W-1:0] rq,
			input logic [IDX_W-1:0] ix, input logic nl);
		pool_resp_t r;
		int cnt;
		int sz;
		int prod;
		logic [CNT_W-1:0] got;
		r = '0;
		cnt = (count_reg_q > POOL_MAX) ? POOL_MAX : int'(count_reg_q);
		sz = (size_reg_q > SIZE_LIMIT) ? SIZE_LIMIT : int'(size_reg_q);
		case (rq)
			REQ_ALLOC: begin
				if (free_head_q >= LINK_NULL) begin
					r.status = STS_EMPTY;
				end else begin
					got = free_head_q;
					free_head_q = link_mem_q[got[IDX_W-1:0]];
					if (free_head_q > LINK_NULL)
						free_head_q = LINK_NULL;
					prod = int'(got) * sz;
					r.status = STS_OK;
					r.idx = got[IDX_W-1:0];
					r.offset = prod[OFF_W-1:0];
				end
			end
			REQ_FREE: begin
				if (nl) begin
					r.status = STS_NULL_FREE;
				end else if (int'(ix) >= cnt) begin
					r.status = STS_RANGE;
				end else begin
					// push onto the head; double frees go through unchecked
					link_mem_q[ix] = free_head_q;
					free_head_q = {1'b0, ix};
					r.status = STS_OK;
				end
			end
			REQ_REINIT: begin
				for (int i = 0; i < cnt; i++)
					link_mem_q[i] = (i + 1 < cnt) ? CNT_W'(i + 1) : LINK_NULL;
				free_head_q = (cnt > 0) ? '0 : LINK_NULL;
				r.status = STS_OK;
			end
			default: r.status = STS_OK;
		endcase
		return r;
	endfunction

	function automatic void check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Driver: hold the current item until it is taken, then advance or idle
	always @(negedge clk) begin
		if (!s_tvalid || req_taken) begin
			if (req_backlog.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				drv_item = req_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= drv_item.idx;
				s_tuser <= {drv_item.nul, drv_item.req};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	// Monitor: check each result item against the oldest prediction, predict each
	// accepted request item, and track register writes into the shadow pool
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_resp.status = m_tuser;
				got_resp.idx = m_tdata[7:0];
				got_resp.offset = m_tdata[27:8];
				if (due_responses.size() == 0) begin
					$error("result item with no request outstanding: status %0d idx %0d",
						got_resp.status, got_resp.idx);
					errors++;
				end else begin
					exp_resp = due_responses.pop_front();
					check_field("status", exp_resp.status, got_resp.status);
					check_field("block_index_res", exp_resp.idx, got_resp.idx);
					check_field("byte_offset", exp_resp.offset, got_resp.offset);
				end
			end
			if (s_tvalid && s_tready) begin
				due_responses.push_back(pool_response(s_tuser[1:0], s_tdata, s_tuser[2]));
				n_accepted++;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_BLOCK_COUNT: count_reg_q = cfg_data[CNT_W-1:0];
					CFG_BLOCK_SIZE:  size_reg_q = cfg_data;
					default: ;
				endcase
			end
		end
		req_taken = arst_n && s_tvalid && s_tready;
	end

	task automatic queue_req(input logic [REQ_W-1:0] rq, input logic [IDX_W-1:0] ix,
			input logic nl);
		req_backlog.push_back(pool_req_t'{req: rq, idx: ix, nul: nl});
		n_queued++;
	endtask

	// Wait until every request is taken and answered, then let the
	// block settle before anything touches the registers
	task automatic wait_drained();
		while (!(n_accepted == n_queued && due_responses.size() == 0))
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input int unsigned v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ri;
		cfg_data <= v[SIZE_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly allocs and in-range frees, with a few reinits, null frees,
	// stray indexes and unused codes mixed in
	task automatic queue_random_reqs(input int n, input int alloc_pct);
		int roll;
		int cnt;
		logic [IDX_W-1:0] ix;
		for (int k = 0; k < n; k++) begin
			cnt = (count_reg_q > POOL_MAX) ? POOL_MAX : int'(count_reg_q);
			roll = $urandom_range(99);
			ix = IDX_W'($urandom_range(255));
			if (roll < alloc_pct) begin
				queue_req(REQ_ALLOC, ix, 1'($urandom_range(1)));
			end else if (roll < 94) begin
				if (cnt > 0 && $urandom_range(9) != 0)
					ix = IDX_W'($urandom_range(cnt - 1));
				queue_req(REQ_FREE, ix, $urandom_range(19) == 0);
			end else if (roll < 98) begin
				queue_req(REQ_REINIT, ix, 1'($urandom_range(1)));
			end else begin
				queue_req(REQ_UNUSED, ix, 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		free_head_q = LINK_NULL;
		count_reg_q = COUNT_RST;
		size_reg_q = SIZE_RST;
		for (int i = 0; i < POOL_MAX; i++)
			link_mem_q[i] = '0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		snd_idle_pct = 26;
		rcv_idle_pct = 69;

		// Reset values: empty pool, 256 blocks of 64 bytes
		queue_req(REQ_ALLOC, 8'hFF, 1'b1);   // pop from an empty pool
		queue_req(REQ_FREE, 8'hFF, 1'b1);    // null handle, any index
		queue_req(REQ_FREE, 8'h00, 1'b0);
		queue_req(REQ_ALLOC, 8'h00, 1'b0);
		queue_req(REQ_ALLOC, 8'h00, 1'b0);   // empty again
		queue_req(REQ_UNUSED, 8'hFF, 1'b1);
		queue_req(REQ_REINIT, 8'h00, 1'b0);
		queue_req(REQ_ALLOC, 8'h00, 1'b0);
		queue_req(REQ_ALLOC, 8'h00, 1'b0);
		queue_req(REQ_FREE, 8'hFF, 1'b0);    // top index, in range
		queue_req(REQ_ALLOC, 8'h00, 1'b0);
		wait_drained();

		// Tiny pool, size beyond the cap
		write_reg(CFG_BLOCK_COUNT, 3);
		write_reg(CFG_BLOCK_SIZE, 8191);
		queue_req(REQ_REINIT, 8'h00, 1'b0);
		queue_req(REQ_FREE, 8'd3, 1'b0);     // first index past the count
		queue_req(REQ_FREE, 8'hFF, 1'b0);
		repeat (4) queue_req(REQ_ALLOC, 8'h00, 1'b0);
		queue_req(REQ_FREE, 8'd2, 1'b0);
		queue_req(REQ_ALLOC, 8'h00, 1'b0);
		wait_drained();

		// Zero count and zero size
		write_reg(CFG_BLOCK_COUNT, 0);
		write_reg(CFG_BLOCK_SIZE, 0);
		queue_req(REQ_REINIT, 8'h00, 1'b0);
		queue_req(REQ_ALLOC, 8'h00, 1'b0);
		queue_req(REQ_FREE, 8'h00, 1'b0);
		wait_drained();

		// Random phases; the free list carries over, so a lowered count still
		// leaves old blocks on the list
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					write_reg(CFG_BLOCK_COUNT, 511);
					write_reg(CFG_BLOCK_SIZE, 0);
				end
				1: begin
					write_reg(CFG_BLOCK_COUNT, 1);
					write_reg(CFG_BLOCK_SIZE, 4096);
				end
				2: begin
					write_reg(CFG_BLOCK_COUNT, 256);
					write_reg(CFG_BLOCK_SIZE, 8191);
				end
				3: begin
					write_reg(CFG_BLOCK_COUNT, 2);
					write_reg(CFG_BLOCK_SIZE, 1);
				end
				4: begin
					write_reg(CFG_BLOCK_COUNT, $urandom_range(256, 1));
					write_reg(CFG_BLOCK_SIZE, $urandom_range(4096, 1));
				end
				default: begin
					write_reg(CFG_BLOCK_COUNT, $urandom_range(511));
					write_reg(CFG_BLOCK_SIZE, $urandom_range(8191));
				end
			endcase
			if (p < 2) begin
				snd_idle_pct = 26;
				rcv_idle_pct = 69;
			end else if (p < 4) begin
				snd_idle_pct = 69;
				rcv_idle_pct = 26;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			if (p % 2 == 0)
				queue_req(REQ_REINIT, 8'h00, 1'b0);
			queue_random_reqs(205, $urandom_range(56, 40));
			wait_drained();
		end

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
